/* hw/rtl/depq_pkg.sv */
// Shared types, constants and helpers for the double-ended priority queue.
`timescale 1ns / 1ps
package depq_pkg;

    localparam int SIDE_DEPTH = 512;
    localparam int KEY_BITS   = 31;
    localparam int TAG_BITS   = 16;
    localparam int IDX_W      = $clog2(SIDE_DEPTH);
    localparam int CNT_W      = $clog2(SIDE_DEPTH + 1);
    localparam int WIDE_W     = IDX_W + 2;
    localparam int OCC_W      = 11;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_POP_MIN = 2'd1;
    localparam logic [1:0] OP_POP_MAX = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] out_key;
        logic [TAG_BITS-1:0] out_tag;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD0,
        S_POP_RD1,
        S_POP_MV,
        S_SD_CHK,
        S_SD_L,
        S_SD_R,
        S_SD_CMP,
        S_CLIP,
        S_CROSS,
        S_SU_CHK,
        S_SU_CMP,
        S_DONE
    } t_step;

    typedef struct packed {
        t_step step;
        logic  take;
        logic  load;
    } t_cmd;

    typedef struct packed {
        logic dec_err;
        logic dec_ins;
        logic dec_pop;
        logic direct;
        logic lone;
        logic drained;
        logic has_left;
        logic has_right;
        logic other_empty;
        logic better;
        logic clip_more;
        logic idx_zero;
        logic pend;
        logic ins;
    } t_dp_status;

    // true when key a must sit above key b on the given side (1 = max side)
    function automatic logic ahead(input logic hi, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        return hi ? (a > b) : (a < b);
    endfunction

endpackage

/* hw/rtl/depq_ctrl.sv */
// Sequencing state machine for the double-ended priority queue.
`timescale 1ns / 1ps
module depq_ctrl import depq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_cmd       o_cmd
);

    t_step r_state, n_state;
    logic  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.step = r_state;
        o_cmd.take = 1'b0;
        o_cmd.load = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.dec_err) begin
                    n_state = S_DONE;
                end else if (i_status.dec_ins) begin
                    n_state = i_status.direct ? S_SU_CHK : S_CLIP;
                end else if (i_status.dec_pop) begin
                    n_state = S_POP_RD0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_RD0: n_state = S_POP_RD1;
            S_POP_RD1: n_state = i_status.lone ? S_DONE : S_POP_MV;
            S_POP_MV:  n_state = i_status.drained ? S_DONE : S_SD_CHK;
            S_SD_CHK: begin
                if (i_status.has_left) begin
                    n_state = S_SD_L;
                end else begin
                    n_state = i_status.other_empty ? S_DONE : S_CLIP;
                end
            end
            S_SD_L: n_state = i_status.has_right ? S_SD_R : S_SD_CMP;
            S_SD_R: n_state = S_SD_CMP;
            S_SD_CMP: begin
                if (i_status.better) begin
                    n_state = S_SD_CHK;
                end else begin
                    n_state = i_status.other_empty ? S_DONE : S_CLIP;
                end
            end
            S_CLIP: n_state = i_status.clip_more ? S_CLIP : S_CROSS;
            S_CROSS: begin
                n_state = (i_status.better || i_status.ins) ? S_SU_CHK : S_DONE;
            end
            S_SU_CHK: begin
                if (i_status.idx_zero) begin
                    n_state = i_status.pend ? S_SU_CHK : S_DONE;
                end else begin
                    n_state = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                if (i_status.better) begin
                    n_state = S_SU_CHK;
                end else begin
                    n_state = i_status.pend ? S_SU_CHK : S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/depq_dp.sv */
// Datapath of the double-ended priority queue: side stores, counts, sift registers.
`timescale 1ns / 1ps
module depq_dp import depq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_item   i_in_data,
    output t_dp_status o_status,
    output t_out_item  o_out_data
);

    t_entry r_mem_lo [SIDE_DEPTH];
    t_entry r_mem_hi [SIDE_DEPTH];
    t_entry r_rd_lo, r_rd_hi;
    logic   r_rd_sel;

    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [CNT_W-1:0]    r_lc, r_hc;
    logic                r_side, r_pend, r_lone, r_mside;
    logic [IDX_W-1:0]    r_idx, r_cidx, r_home;
    t_entry              r_val, r_alt, r_res;
    logic [1:0]          r_status;
    t_out_item           r_out;

    logic             rd_side, wr_en, wr_side;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    t_entry           wr_data, rdata;

    logic             t_side, full_t, lih, ins, better, sd_end, su_end;
    logic [CNT_W-1:0] cnt_t, cnt_o, cur_cnt, oth_cnt;
    logic [WIDE_W-1:0] lft, rgt;
    logic [IDX_W-1:0] parent;

    function automatic logic full_cnt(input logic [CNT_W-1:0] n);
        return ((n + CNT_W'(1)) & n) == '0;
    endfunction

    assign rdata   = r_rd_sel ? r_rd_hi : r_rd_lo;
    assign t_side  = !((r_lc == r_hc) || !full_cnt(r_lc));
    assign cnt_t   = t_side ? r_hc : r_lc;
    assign cnt_o   = t_side ? r_lc : r_hc;
    assign full_t  = cnt_t >= CNT_W'(SIDE_DEPTH);
    assign cur_cnt = r_side ? r_hc : r_lc;
    assign oth_cnt = r_side ? r_lc : r_hc;
    assign lih     = (r_hc != '0) && ((r_hc == r_lc) || !full_cnt(r_hc));
    assign ins     = (r_op == OP_INSERT);
    assign lft     = {1'b0, r_idx, 1'b1};
    assign rgt     = lft + WIDE_W'(1);
    assign parent  = (r_idx - IDX_W'(1)) >> 1;

    always_comb begin
        case (i_cmd.step)
            S_SD_R:   better = ahead(r_side, rdata.key, r_alt.key);
            S_SD_CMP: better = ahead(r_side, r_alt.key, r_val.key);
            default:  better = ahead(r_side, r_val.key, rdata.key);
        endcase
    end

    always_comb begin
        o_status.dec_err = 1'b0;
        case (r_op)
            OP_INSERT:  o_status.dec_err = full_t;
            OP_POP_MIN: o_status.dec_err = (r_lc == '0);
            OP_POP_MAX: o_status.dec_err = (r_lc == '0) && (r_hc == '0);
            default:    o_status.dec_err = 1'b0;
        endcase
        o_status.dec_ins     = ins;
        o_status.dec_pop     = (r_op == OP_POP_MIN) || (r_op == OP_POP_MAX);
        o_status.direct      = (cnt_o == '0);
        o_status.lone        = r_lone;
        o_status.drained     = (r_mside == r_side) && (cur_cnt == CNT_W'(1));
        o_status.has_left    = lft < WIDE_W'(cur_cnt);
        o_status.has_right   = rgt < WIDE_W'(cur_cnt);
        o_status.other_empty = (oth_cnt == '0);
        o_status.better      = better;
        o_status.clip_more   = (CNT_W'(r_idx) >= cur_cnt) && (r_idx != '0);
        o_status.idx_zero    = (r_idx == '0);
        o_status.pend        = r_pend;
        o_status.ins         = ins;
    end

    assign sd_end = ((i_cmd.step == S_SD_CHK) && !o_status.has_left) ||
                    ((i_cmd.step == S_SD_CMP) && !better);
    assign su_end = ((i_cmd.step == S_SU_CHK) && o_status.idx_zero) ||
                    ((i_cmd.step == S_SU_CMP) && !better);

    // memory port control
    always_comb begin
        rd_side = r_side;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_side = r_side;
        wr_addr = r_idx;
        wr_data = r_val;
        case (i_cmd.step)
            S_POP_RD0: rd_addr = '0;
            S_POP_RD1: begin
                rd_side = lih;
                rd_addr = lih ? IDX_W'(r_hc - CNT_W'(1)) : IDX_W'(r_lc - CNT_W'(1));
            end
            S_SD_CHK: begin
                if (o_status.has_left) begin
                    rd_addr = lft[IDX_W-1:0];
                end else begin
                    wr_en = o_status.other_empty;
                end
            end
            S_SD_L: rd_addr = rgt[IDX_W-1:0];
            S_SD_CMP: begin
                if (better) begin
                    wr_en   = 1'b1;
                    wr_data = r_alt;
                end else begin
                    wr_en = o_status.other_empty;
                end
            end
            S_CROSS: begin
                wr_en   = !ins;
                wr_side = !r_side;
                wr_addr = r_home;
                wr_data = better ? rdata : r_val;
            end
            S_SU_CHK: begin
                if (o_status.idx_zero) begin
                    wr_en = 1'b1;
                end else begin
                    rd_addr = parent;
                end
            end
            S_SU_CMP: begin
                wr_en   = 1'b1;
                wr_data = better ? rdata : r_val;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_side) begin
            r_mem_lo[wr_addr] <= wr_data;
        end
        if (wr_en && wr_side) begin
            r_mem_hi[wr_addr] <= wr_data;
        end
        r_rd_lo  <= r_mem_lo[rd_addr];
        r_rd_hi  <= r_mem_hi[rd_addr];
        r_rd_sel <= rd_side;
    end

    // side counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= '0;
            r_hc <= '0;
        end else begin
            case (i_cmd.step)
                S_DECODE: begin
                    if (ins && !full_t) begin
                        if (t_side) begin
                            r_hc <= r_hc + CNT_W'(1);
                        end else begin
                            r_lc <= r_lc + CNT_W'(1);
                        end
                    end
                end
                S_POP_RD1: begin
                    if (r_lone) begin
                        r_lc <= '0;
                    end
                end
                S_POP_MV: begin
                    if (r_mside) begin
                        r_hc <= r_hc - CNT_W'(1);
                    end else begin
                        r_lc <= r_lc - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_in_data.opcode;
            r_key <= i_in_data.key;
            r_tag <= i_in_data.tag;
        end
        case (i_cmd.step)
            S_DECODE: begin
                r_res    <= '0;
                r_pend   <= 1'b0;
                r_val    <= '{key: r_key, tag: r_tag};
                r_idx    <= IDX_W'(cnt_t);
                r_home   <= IDX_W'(cnt_t);
                case (r_op)
                    OP_INSERT: begin
                        r_status <= full_t ? STAT_FULL : STAT_OK;
                        r_lone   <= 1'b0;
                        r_side   <= (cnt_o == '0) ? t_side : !t_side;
                    end
                    OP_POP_MIN: begin
                        r_status <= (r_lc == '0) ? STAT_EMPTY : STAT_OK;
                        r_lone   <= 1'b0;
                        r_side   <= 1'b0;
                    end
                    OP_POP_MAX: begin
                        r_status <= ((r_lc == '0) && (r_hc == '0)) ? STAT_EMPTY : STAT_OK;
                        r_lone   <= (r_hc == '0);
                        r_side   <= (r_hc != '0);
                    end
                    default: begin
                        r_status <= STAT_OK;
                        r_lone   <= 1'b0;
                        r_side   <= 1'b0;
                    end
                endcase
            end
            S_POP_RD1: begin
                r_res   <= rdata;
                r_mside <= lih;
            end
            S_POP_MV: begin
                r_val <= rdata;
                r_idx <= '0;
            end
            S_SD_L: begin
                r_alt  <= rdata;
                r_cidx <= lft[IDX_W-1:0];
            end
            S_SD_R: begin
                if (better) begin
                    r_alt  <= rdata;
                    r_cidx <= rgt[IDX_W-1:0];
                end
            end
            S_CLIP: begin
                if (o_status.clip_more) begin
                    r_idx <= parent;
                end
            end
            S_CROSS: begin
                if (ins) begin
                    if (better) begin
                        r_alt  <= rdata;
                        r_pend <= 1'b1;
                    end else begin
                        r_side <= !r_side;
                        r_idx  <= r_home;
                    end
                end
            end
            S_DONE: begin
                if (i_cmd.load) begin
                    r_out <= '{status: r_status, out_key: r_res.key, out_tag: r_res.tag,
                               occupancy: OCC_W'(r_lc) + OCC_W'(r_hc)};
                end
            end
            default: ;
        endcase
        // end of sift-down: hand over to the cross-side check
        if (sd_end && !o_status.other_empty) begin
            r_home <= r_idx;
            r_side <= !r_side;
        end
        if ((i_cmd.step == S_SD_CMP) && better) begin
            r_idx <= r_cidx;
        end
        if ((i_cmd.step == S_SU_CMP) && better) begin
            r_idx <= parent;
        end
        // end of sift-up: start the deferred sift on the home side
        if (su_end && r_pend) begin
            r_side <= !r_side;
            r_idx  <= r_home;
            r_val  <= r_alt;
            r_pend <= 1'b0;
        end
    end

    assign o_out_data = r_out;

endmodule

/* hw/rtl/double_ended_priority_queue_core.sv */
// Top level of the double-ended priority queue (deap) core.
// Holds up to 1023 key/tag pairs in two 512-entry single-read-port stores, a
// min-ordered low side and a max-ordered high side. One transaction is worked
// at a time; each store has one read and one write a cycle with registered
// read data. An insert climbs the heap on each side that it touches, with clip
// steps between; a pop reads the root and the last entry, sifts down, clips,
// checks the other side and climbs. Errors and unused opcodes go straight
// from decode to the done step. A new input is taken once the previous
// result sits in the output register.
`timescale 1ns / 1ps
module double_ended_priority_queue_core import depq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd       cmd;
    t_dp_status dp_status;

    depq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    depq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

endmodule

/* hw/rtl/depq_chk.sv */
// Port-level assertions for the double-ended priority queue core.
`timescale 1ns / 1ps
module depq_chk import depq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a transaction is in progress");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STAT_OK) |->
            (o_out_data.out_key == '0) && (o_out_data.out_tag == '0))
        else $error("error result carries a key or tag");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.occupancy < OCC_W'(2 * SIDE_DEPTH))
        else $error("occupancy beyond capacity");

endmodule

bind double_ended_priority_queue_core depq_chk u_depq_chk (.*);
